// File: sv/gift128_pkg.sv
// GIFT-128 shared types, constants and bit-level round functions.
// Used by gift128_round and gift128_block_cipher_top; no dependencies.
package gift128_pkg;

  localparam int BlockW = 128;
  localparam int RcW    = 6;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [RcW-1:0]    rc_t;

  typedef struct packed {
    logic valid;
    logic cmd;
  } ctl_t;

  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'h1;
      4'h1: y = 4'hA;
      4'h2: y = 4'h4;
      4'h3: y = 4'hC;
      4'h4: y = 4'h6;
      4'h5: y = 4'hF;
      4'h6: y = 4'h3;
      4'h7: y = 4'h9;
      4'h8: y = 4'h2;
      4'h9: y = 4'hD;
      4'hA: y = 4'hB;
      4'hB: y = 4'h7;
      4'hC: y = 4'h5;
      4'hD: y = 4'h0;
      4'hE: y = 4'h8;
      default: y = 4'hE;
    endcase
    return y;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hD;
      4'h1: y = 4'h0;
      4'h2: y = 4'h8;
      4'h3: y = 4'h6;
      4'h4: y = 4'h2;
      4'h5: y = 4'hC;
      4'h6: y = 4'h4;
      4'h7: y = 4'hB;
      4'h8: y = 4'hE;
      4'h9: y = 4'h7;
      4'hA: y = 4'h1;
      4'hB: y = 4'hA;
      4'hC: y = 4'h3;
      4'hD: y = 4'h9;
      4'hE: y = 4'hF;
      default: y = 4'h5;
    endcase
    return y;
  endfunction

  function automatic block_t sub_fwd(input block_t x);
    block_t y;
    for (int k = 0; k < 32; k++) begin
      y[4*k +: 4] = sbox_fwd(x[4*k +: 4]);
    end
    return y;
  endfunction

  function automatic block_t sub_inv(input block_t x);
    block_t y;
    for (int k = 0; k < 32; k++) begin
      y[4*k +: 4] = sbox_inv(x[4*k +: 4]);
    end
    return y;
  endfunction

  function automatic int perm_pos(input int i);
    int q;
    q = i & 3;
    return 4 * (i >> 4) + 32 * (((3 * ((i & 15) >> 2)) + q) & 3) + q;
  endfunction

  function automatic block_t perm_fwd(input block_t x);
    block_t y;
    for (int i = 0; i < BlockW; i++) begin
      y[perm_pos(i)] = x[i];
    end
    return y;
  endfunction

  function automatic block_t perm_inv(input block_t x);
    block_t y;
    for (int i = 0; i < BlockW; i++) begin
      y[i] = x[perm_pos(i)];
    end
    return y;
  endfunction

  function automatic block_t add_round_key(input block_t x, input block_t k, input rc_t rc);
    block_t y;
    y = x;
    for (int i = 0; i < 32; i++) begin
      y[4*i+2] = y[4*i+2] ^ k[64+i];
      y[4*i+1] = y[4*i+1] ^ k[i];
    end
    for (int i = 0; i < RcW; i++) begin
      y[4*i+3] = y[4*i+3] ^ rc[i];
    end
    y[BlockW-1] = ~y[BlockW-1];
    return y;
  endfunction

  function automatic block_t key_update(input block_t k);
    return {k[17:16], k[31:18], k[11:0], k[15:12], k[127:32]};
  endfunction

  function automatic block_t key_revert(input block_t k);
    return {k[95:0], k[125:112], k[127:126], k[99:96], k[111:100]};
  endfunction

  // position of key bit b after n key updates
  function automatic int key_pos(input int b, input int n);
    int p;
    p = b;
    for (int i = 0; i < n; i++) begin
      if (p >= 32) begin
        p = p - 32;
      end else if (p >= 16) begin
        p = 112 + ((p - 2) & 15);
      end else begin
        p = 96 + ((p + 4) & 15);
      end
    end
    return p;
  endfunction

  // round constant used by round n (from 0)
  function automatic rc_t rc_at(input int n);
    rc_t c;
    c = '0;
    for (int i = 0; i <= n; i++) begin
      c = {c[4:0], c[5] ^ c[4] ^ 1'b1};
    end
    return c;
  endfunction

endpackage

// File: sv/gift128_block_cipher_top.sv
// GIFT-128 encrypt/decrypt core: one round per pipeline stage, two-word output buffer.
// An accepted word passes through every round stage register and then into the output buffer,
// from whose head register it is presented on the output and can be popped.
// Throughput: one word per cycle; the round pipeline freezes while the output buffer is full.
// Reset clears stage valid bits and the buffer count; no other pass is needed.
// Depends on gift128_pkg and gift128_round.
module gift128_block_cipher_top #(
  parameter int ROUNDS = 40
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [255:0] s_axis_tdata_i,  // key_hi, key_lo, data_hi, data_lo
  input  logic         s_axis_tuser_i,  // cmd
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o   // result_hi, result_lo
);
  import gift128_pkg::*;

  ctl_t   stg_ctl   [ROUNDS+1];
  block_t stg_state [ROUNDS+1];
  block_t stg_key   [ROUNDS+1];

  block_t key_in, key_jump, data_in;
  logic   en;
  logic   push, pop;
  logic [1:0] count_d, count_q;
  block_t head_d, head_q, tail_d, tail_q;

  assign key_in  = {s_axis_tdata_i[63:0], s_axis_tdata_i[127:64]};
  assign data_in = {s_axis_tdata_i[191:128], s_axis_tdata_i[255:192]};

  for (genvar b = 0; b < BlockW; b++) begin : g_jump
    localparam int Pos = key_pos(b, ROUNDS - 1);
    assign key_jump[Pos] = key_in[b];
  end

  assign en              = (count_q != 2'd2);
  assign s_axis_tready_o = en;

  assign stg_ctl[0]   = '{valid: s_axis_tvalid_i, cmd: s_axis_tuser_i};
  assign stg_state[0] = data_in;
  assign stg_key[0]   = (s_axis_tuser_i == CmdDecrypt) ? key_jump : key_in;

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    gift128_round #(
      .RC_ENC (rc_at(g)),
      .RC_DEC (rc_at(ROUNDS - 1 - g))
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .ctl_i   (stg_ctl[g]),
      .state_i (stg_state[g]),
      .key_i   (stg_key[g]),
      .ctl_o   (stg_ctl[g+1]),
      .state_o (stg_state[g+1]),
      .key_o   (stg_key[g+1])
    );
  end

  assign push = en && stg_ctl[ROUNDS].valid;
  assign pop  = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    tail_d  = tail_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
      if (count_q == 2'd0) begin
        head_d = stg_state[ROUNDS];
      end else begin
        tail_d = stg_state[ROUNDS];
      end
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
      head_d  = tail_q;
    end else if (push && pop) begin
      head_d = stg_state[ROUNDS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign m_axis_tvalid_o = (count_q != 2'd0);
  assign m_axis_tdata_o  = {head_q[63:0], head_q[127:64]};

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output buffer count out of range");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 2'd1)
    else $error("output buffer count missed a push");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> count_q == $past(count_q) - 2'd1)
    else $error("output buffer count missed a pop");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(stg_ctl[ROUNDS].valid))
    else $error("last round stage moved during stall");
`endif

endmodule

// File: sv/gift128_round.sv
// One GIFT-128 round stage, encrypt or decrypt per word, with its pipeline register.
// Depends on gift128_pkg.
module gift128_round #(
  parameter logic [5:0] RC_ENC = 6'h01,
  parameter logic [5:0] RC_DEC = 6'h01
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  gift128_pkg::ctl_t     ctl_i,
  input  gift128_pkg::block_t   state_i,
  input  gift128_pkg::block_t   key_i,
  output gift128_pkg::ctl_t     ctl_o,
  output gift128_pkg::block_t   state_o,
  output gift128_pkg::block_t   key_o
);
  import gift128_pkg::*;

  logic   valid_q;
  logic   cmd_q;
  block_t state_d, state_q;
  block_t key_d, key_q;
  block_t enc_state, dec_state;

  assign enc_state = add_round_key(perm_fwd(sub_fwd(state_i)), key_i, RC_ENC);
  assign dec_state = sub_inv(perm_inv(add_round_key(state_i, key_i, RC_DEC)));

  always_comb begin
    if (ctl_i.cmd == CmdDecrypt) begin
      state_d = dec_state;
      key_d   = key_revert(key_i);
    end else begin
      state_d = enc_state;
      key_d   = key_update(key_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd_q   <= ctl_i.cmd;
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign ctl_o   = '{valid: valid_q, cmd: cmd_q};
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule
